// File: hw/rtl/lfrs_pkg.sv
// Shared types and constants of the LCD frame refresh serializer.
package lfrs_pkg;

  localparam logic [7:0] HDR_COMMAND    = 8'hF8;
  localparam logic [7:0] HDR_DATA       = 8'hFA;
  localparam logic [7:0] NIBBLE_MASK    = 8'hF0;
  localparam logic [7:0] ROW_CMD        = 8'h80;
  localparam logic [7:0] COL_CMD_TOP    = 8'h80;
  localparam logic [7:0] COL_CMD_BOTTOM = 8'h88;

  localparam logic [6:0] HALF_ROWS      = 7'd32;
  localparam logic [6:0] MAX_ROWS       = 7'd64;
  localparam logic [6:0] ROWS_RESET     = 7'd64;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       last_of_run;
    logic       frame_done;
  } out_item_t;

  // One run of transfers caused by a single input item.
  typedef struct packed {
    logic [7:0] row_cmd;
    logic [7:0] col_cmd;
    logic [7:0] pixel;
    logic       data_only;
    logic       done;
  } run_t;

  // Handshake between the sequencer and the serializer.
  typedef struct packed {
    logic load;
  } run_hs_t;

  typedef enum logic [1:0] {
    XF_ROW,
    XF_COL,
    XF_DATA
  } xfer_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_HIGH,
    PH_LOW
  } phase_t;

endpackage

// File: hw/rtl/lfrs_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface lfrs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/lfrs_sequencer.sv
// Row, column and pair tracking; builds the transfer run for each input item.
module lfrs_sequencer #(
  parameter int COLUMN_WORDS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data,
  lfrs_stream_if.sink     in_chan,
  input  logic            run_ready,
  output lfrs_pkg::run_hs_t run_hs,
  output lfrs_pkg::run_t  run_nxt
);
  import lfrs_pkg::*;

  localparam int COL_W = (COLUMN_WORDS > 1) ? $clog2(COLUMN_WORDS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMN_WORDS - 1);

  logic [6:0]       rows_in_use_r;
  logic [5:0]       row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             second_r, second_nxt;

  logic             accept;
  logic [5:0]       row_cur;
  logic [COL_W-1:0] col_cur;
  logic             second_cur;
  logic [6:0]       limit;
  logic [5:0]       row_inc;
  logic             top_half;
  logic             done;

  assign accept        = in_chan.valid && run_ready;
  assign in_chan.ready = run_ready;
  assign run_hs.load   = accept;

  always_comb begin
    // A restart clears the position before this item is handled.
    row_cur    = in_chan.payload.frame_restart ? 6'd0 : row_r;
    col_cur    = in_chan.payload.frame_restart ? '0 : col_r;
    second_cur = in_chan.payload.frame_restart ? 1'b0 : second_r;

    if (rows_in_use_r == 7'd0) begin
      limit = 7'd1;
    end else if (rows_in_use_r > MAX_ROWS) begin
      limit = MAX_ROWS;
    end else begin
      limit = rows_in_use_r;
    end

    top_half = {1'b0, row_cur} < HALF_ROWS;
    row_inc  = row_cur + 6'd1;

    row_nxt    = row_cur;
    col_nxt    = col_cur;
    second_nxt = ~second_cur;
    done       = 1'b0;
    if (second_cur) begin
      if (col_cur == COL_LAST) begin
        col_nxt = '0;
        if (row_inc == 6'd0 || {1'b0, row_inc} >= limit) begin
          row_nxt = 6'd0;
          done    = 1'b1;
        end else begin
          row_nxt = row_inc;
        end
      end else begin
        col_nxt = col_cur + COL_W'(1);
      end
    end

    run_nxt.row_cmd   = top_half ? (ROW_CMD | {2'b00, row_cur})
                                 : (ROW_CMD | ({2'b00, row_cur} - {1'b0, HALF_ROWS}));
    run_nxt.col_cmd   = (top_half ? COL_CMD_TOP : COL_CMD_BOTTOM) | 8'(col_cur);
    run_nxt.pixel     = in_chan.payload.pixel_byte;
    run_nxt.data_only = second_cur;
    run_nxt.done      = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      row_r         <= 6'd0;
      col_r         <= '0;
      second_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        rows_in_use_r <= cfg_data;
      end
      if (accept) begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        second_r <= second_nxt;
      end
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} <= {1'b0, COL_LAST})
    else $error("column counter beyond the row width");

  a_pair_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_chan.payload.frame_restart |=> second_r != $past(second_r))
    else $error("pair position did not advance on an accepted item");

  a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> row_r == 6'd0 && col_r == '0 && !second_r)
    else $error("frame end did not return to the first position");

endmodule

// File: hw/rtl/lfrs_serializer.sv
// Run register and byte sequencer that emits three-byte transfers one at a time.
module lfrs_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  lfrs_pkg::run_hs_t run_hs,
  input  lfrs_pkg::run_t   run_nxt,
  output logic             run_ready,
  lfrs_stream_if.source    out_chan
);
  import lfrs_pkg::*;

  run_t   run_r;
  logic   run_valid_r;
  xfer_t  xfer_r;
  phase_t phase_r;

  logic       last;
  logic       take;
  logic [7:0] value;
  logic [7:0] byte_out;

  assign last      = (xfer_r == XF_DATA) && (phase_r == PH_LOW);
  assign take      = run_valid_r && out_chan.ready;
  // The next run may load in the cycle the current one hands over its last byte.
  assign run_ready = !run_valid_r || (out_chan.ready && last);

  always_comb begin
    unique case (xfer_r)
      XF_ROW:  value = run_r.row_cmd;
      XF_COL:  value = run_r.col_cmd;
      XF_DATA: value = run_r.pixel;
      default: value = run_r.pixel;
    endcase
    unique case (phase_r)
      PH_HEADER: byte_out = (xfer_r == XF_DATA) ? HDR_DATA : HDR_COMMAND;
      PH_HIGH:   byte_out = value & NIBBLE_MASK;
      PH_LOW:    byte_out = {value[3:0], 4'h0};
      default:   byte_out = HDR_COMMAND;
    endcase
  end

  assign out_chan.valid               = run_valid_r;
  assign out_chan.payload.serial_byte = byte_out;
  assign out_chan.payload.last_of_run = last;
  assign out_chan.payload.frame_done  = last && run_r.done;

  always_ff @(posedge clk) begin
    if (run_hs.load) begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      xfer_r      <= XF_ROW;
      phase_r     <= PH_HEADER;
    end else if (run_hs.load) begin
      run_valid_r <= 1'b1;
      xfer_r      <= run_nxt.data_only ? XF_DATA : XF_ROW;
      phase_r     <= PH_HEADER;
    end else if (take) begin
      if (last) begin
        run_valid_r <= 1'b0;
      end else begin
        unique case (phase_r)
          PH_HEADER: phase_r <= PH_HIGH;
          PH_HIGH:   phase_r <= PH_LOW;
          PH_LOW: begin
            phase_r <= PH_HEADER;
            xfer_r  <= (xfer_r == XF_ROW) ? XF_COL : XF_DATA;
          end
          default:   phase_r <= PH_HEADER;
        endcase
      end
    end
  end

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    take && last && !run_hs.load |=> !run_valid_r)
    else $error("run register still full after its last byte");

  a_short_run_data: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r && run_r.data_only |-> xfer_r == XF_DATA)
    else $error("second byte of a pair sent commands");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    run_hs.load |-> !run_valid_r || (take && last))
    else $error("run loaded over bytes not yet sent");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r && !out_chan.ready |=> $stable(xfer_r) && $stable(phase_r))
    else $error("byte position moved while the output stalled");

endmodule

// File: hw/rtl/lcd_frame_refresh_serializer_unit.sv
// Top level of the LCD frame refresh serializer.
// Latency: the first serial byte of an item is offered the cycle after the item is accepted.
// Throughput: one serial byte per cycle while out_chan is ready, set by the single output
// byte lane; the first item of a pair gives nine serial bytes and the second three.
// The next item is accepted in the cycle that the last byte of the current run is taken.
// Reset (synchronous, active low) clears row, column and pair position and sets rows_in_use to 64.
module lcd_frame_refresh_serializer_unit #(
  parameter int COLUMN_WORDS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data,
  lfrs_stream_if.sink   in_chan,
  lfrs_stream_if.source out_chan
);
  import lfrs_pkg::*;

  run_hs_t run_hs;
  run_t    run_nxt;
  logic    run_ready;

  lfrs_sequencer #(
    .COLUMN_WORDS (COLUMN_WORDS)
  ) u_sequencer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .run_ready (run_ready),
    .run_hs    (run_hs),
    .run_nxt   (run_nxt)
  );

  lfrs_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_hs    (run_hs),
    .run_nxt   (run_nxt),
    .run_ready (run_ready),
    .out_chan  (out_chan)
  );

endmodule

// File: verif/lcd_frame_refresh_serializer_unit_test.sv
// Self-checking testbench for the LCD frame refresh serializer top level.
module lcd_frame_refresh_serializer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrs_pkg::*;

  localparam int COLUMN_WORDS = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_GAP   = 4;
  localparam int TAB_ROWS     = 24;

  // One directed item, optionally preceded by a register write. Where known is set,
  // bytes holds the typed-in serial bytes of the run, last byte in the low octet.
  typedef struct packed {
    logic        wr;
    logic [6:0]  cfg;
    logic [7:0]  pix;
    logic        rst;
    logic        known;
    logic        fdone;
    logic [71:0] bytes;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [TAB_ROWS] = '{
    '{1'b0, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 72'hF88000_F88000_FAF0F0},
    '{1'b0, 7'd0, 8'h00, 1'b0, 1'b1, 1'b0, 72'hFA0000},
    '{1'b0, 7'd0, 8'hA5, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h5A, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h3C, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h81, 1'b1, 1'b1, 1'b0, 72'hF88000_F88000_FA8010},
    '{1'b0, 7'd0, 8'h7E, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b1, 7'd1, 8'h12, 1'b1, 1'b1, 1'b0, 72'hF88000_F88000_FA1020},
    '{1'b0, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h80, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h01, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h7F, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hFE, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h55, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hAA, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h0F, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hF0, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h33, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hCC, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h96, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'h69, 1'b0, 1'b0, 1'b0, 72'h0},
    '{1'b0, 7'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 72'hFAF0F0},
    '{1'b1, 7'd0, 8'h00, 1'b0, 1'b1, 1'b0, 72'hF88000_F88000_FA0000}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_data;

  lfrs_stream_if #(.payload_t(in_item_t))  in_chan ();
  lfrs_stream_if #(.payload_t(out_item_t)) out_chan ();

  lcd_frame_refresh_serializer_unit #(
    .COLUMN_WORDS(COLUMN_WORDS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Mirror of the block's frame position and register.
  logic [5:0] lcd_row;
  int         word_col;
  logic       pair_second;
  logic [6:0] rows_reg;

  logic [7:0] run_bytes [$];
  logic       run_done;
  out_item_t  pending_serial [$];

  int cycle_count   = 0;
  int err_count     = 0;
  int items_sent    = 0;
  int bytes_checked = 0;
  int frames_seen   = 0;
  int cfg_writes    = 0;
  int burst_left    = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic add_transfer(input logic [7:0] v, input logic is_data);
    run_bytes.push_back(is_data ? HDR_DATA : HDR_COMMAND);
    run_bytes.push_back(v & NIBBLE_MASK);
    run_bytes.push_back({v[3:0], 4'h0});
  endtask

  task automatic predict_serial_run(input logic [7:0] pix, input logic restart);
    int         limit;
    logic [7:0] row_cmd;
    logic [7:0] col_cmd;
    run_bytes.delete();
    run_done = 1'b0;
    if (restart) begin
      lcd_row     = '0;
      word_col    = 0;
      pair_second = 1'b0;
    end
    limit = rows_reg;
    if (limit == 0) limit = 1;
    if (limit > 64) limit = 64;
    if (!pair_second) begin
      if (lcd_row < HALF_ROWS) begin
        row_cmd = ROW_CMD | {2'b00, lcd_row};
        col_cmd = COL_CMD_TOP | 8'(word_col);
      end else begin
        row_cmd = ROW_CMD | 8'(lcd_row - HALF_ROWS);
        col_cmd = COL_CMD_BOTTOM | 8'(word_col);
      end
      add_transfer(row_cmd, 1'b0);
      add_transfer(col_cmd, 1'b0);
      add_transfer(pix, 1'b1);
      pair_second = 1'b1;
    end else begin
      add_transfer(pix, 1'b1);
      pair_second = 1'b0;
      word_col++;
      if (word_col >= COLUMN_WORDS) begin
        word_col = 0;
        lcd_row  = lcd_row + 6'd1;
        // A row that wraps to zero or reaches the count closes the frame.
        if (lcd_row == 6'd0 || lcd_row >= limit) begin
          lcd_row  = '0;
          run_done = 1'b1;
        end
      end
    end
  endtask

  task automatic queue_run(input logic known, input logic [71:0] typed, input logic typed_done);
    out_item_t e;
    int        n;
    n = run_bytes.size();
    for (int i = 0; i < n; i++) begin
      e.serial_byte = known ? typed[(n - 1 - i) * 8 +: 8] : run_bytes[i];
      e.last_of_run = (i == n - 1);
      e.frame_done  = (i == n - 1) && (known ? typed_done : run_done);
      pending_serial.push_back(e);
    end
  endtask

  task automatic send_item(input logic [7:0] pix, input logic restart, input logic known,
                           input logic [71:0] typed, input logic typed_done);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= '{pixel_byte: pix, frame_restart: restart};
    do @(posedge clk); while (!in_chan.ready);
    predict_serial_run(pix, restart);
    queue_run(known, typed, typed_done);
    items_sent++;
    burst_left--;
  endtask

  // Drops valid and waits until every queued byte has come out.
  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pending_serial.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_rows(input logic [6:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    rows_reg = v;
    cfg_writes++;
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] rows, input int count, input int restart_odds,
                           input logic restart_first);
    logic [7:0] pix;
    logic       restart;
    settle();
    write_rows(rows);
    for (int k = 0; k < count; k++) begin
      restart = (k == 0 && restart_first) ||
                (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
      if ($urandom_range(7) == 0) pix = $urandom_range(1) ? 8'hFF : 8'h00;
      else pix = 8'($urandom);
      send_item(pix, restart, 1'b0, 72'h0, 1'b0);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t e;
    if (pending_serial.size() == 0) begin
      report_mismatch($sformatf("unexpected serial byte %02h", got.serial_byte));
    end else begin
      e = pending_serial.pop_front();
      bytes_checked++;
      if (e.frame_done) frames_seen++;
      if (got.serial_byte !== e.serial_byte)
        report_mismatch($sformatf("serial_byte %02h, expected %02h",
                                  got.serial_byte, e.serial_byte));
      if (got.last_of_run !== e.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                  got.last_of_run, e.last_of_run, e.serial_byte));
      if (got.frame_done !== e.frame_done)
        report_mismatch($sformatf("frame_done %b, expected %b on byte %02h",
                                  got.frame_done, e.frame_done, e.serial_byte));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result(out_chan.payload);
  end

  // Receiver back-pressure: switches between free flow, random stalls and long stalls.
  initial begin
    int   mode;
    int   span;
    int   hold;
    logic lvl;
    logic r;
    out_chan.ready <= 1'b0;
    hold = 0;
    lvl  = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (mode)
          0: r = 1'b1;
          1: r = ($urandom_range(3) != 0);
          2: r = $urandom_range(1);
          default: begin
            if (hold == 0) begin
              hold = lvl ? $urandom_range(1, 10) : $urandom_range(1, 4);
              lvl  = ~lvl;
            end
            hold--;
            r = lvl;
          end
        endcase
        out_chan.ready <= r;
        @(posedge clk);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d bytes still expected",
             cycle_count, pending_serial.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    lcd_row     = '0;
    word_col    = 0;
    pair_second = 1'b0;
    rows_reg    = ROWS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < TAB_ROWS; i++) begin
      if (DIR_TAB[i].wr) begin
        settle();
        write_rows(DIR_TAB[i].cfg);
      end
      send_item(DIR_TAB[i].pix, DIR_TAB[i].rst, DIR_TAB[i].known, DIR_TAB[i].bytes,
                DIR_TAB[i].fdone);
    end

    run_phase(7'd1, 30, 10, 1'b0);
    run_phase(7'd3, 36, 14, 1'b0);
    run_phase(7'd127, 24, 12, 1'b0);
    run_phase(7'd2, 16, 8, 1'b0);
    // A long stretch without restarts walks many rows of one frame.
    run_phase(7'd34, 200, 0, 1'b1);
    // Lowering the count below the current row makes the frame close at the end of the row.
    run_phase(7'd10, 16, 0, 1'b0);
    run_phase(7'd64, 24, 10, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d items and %0d serial bytes, %0d frame ends, %0d register writes",
             items_sent, bytes_checked, frames_seen, cfg_writes);
    $display("row counts 0, 1, 2, 3, 10, 34, 64 and 127, restarts and a count lowered mid-frame");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lfrs_pkg.sv
hw/rtl/lfrs_stream_if.sv
hw/rtl/lfrs_sequencer.sv
hw/rtl/lfrs_serializer.sv
hw/rtl/lcd_frame_refresh_serializer_unit.sv
verif/lcd_frame_refresh_serializer_unit_test.sv
